>>> rtl/core/smmmc_pkg.sv
// shared types and constants for the streaming set statistics block
`default_nettype none

package smmmc_pkg;

    // fixed field widths of the sample and report words
    localparam int SAMPLE_W = 32;
    localparam int CNT_W    = 16;
    localparam int MEAN_W   = 40;

    // parameter defaults
    localparam int DEF_MAX_SAMPLES   = 65535;
    localparam int DEF_SAMPLE_BITS   = 32;
    localparam int DEF_FRACTION_BITS = 8;

    // threshold value after reset
    localparam logic signed [SAMPLE_W-1:0] THR_RESET = 32'sd60;

    // limits of the mean field
    localparam logic signed [MEAN_W-1:0] MEAN_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [MEAN_W-1:0] MEAN_MIN = 40'sh80_0000_0000;

    // shared adder operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

`default_nettype wire

>>> rtl/core/smmmc_if.sv
// sample and report channel interfaces
`default_nettype none

interface smmmc_in_if import smmmc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       no_sample;
    logic                       last;

    modport source (output valid, sample, no_sample, last, input ready);
    modport sink   (input valid, sample, no_sample, last, output ready);
endinterface

interface smmmc_out_if import smmmc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [MEAN_W-1:0]   mean_q8;
    logic signed [SAMPLE_W-1:0] lowest;
    logic signed [SAMPLE_W-1:0] highest;
    logic        [CNT_W-1:0]    passing_count;
    logic        [CNT_W-1:0]    sample_total;
    logic                       overflowed;

    modport source (output valid, mean_q8, lowest, highest, passing_count, sample_total,
                    overflowed, input ready);
    modport sink   (input valid, mean_q8, lowest, highest, passing_count, sample_total,
                    overflowed, output ready);
endinterface

`default_nettype wire

>>> rtl/core/smmmc_alu.sv
// shared add/subtract unit with sign flag
`default_nettype none

module smmmc_alu import smmmc_pkg::*; #(
    parameter int W = 65
) (
    input  t_alu_op              i_op,
    input  logic signed [W-1:0]  i_a,
    input  logic signed [W-1:0]  i_b,
    output logic signed [W-1:0]  o_res,
    output logic                 o_neg
);

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_res = i_a + i_b;
            ALU_SUB: o_res = i_a - i_b;
            default: o_res = i_a - i_b;
        endcase
    end

    // sign of the result: a < b for a subtract
    assign o_neg = o_res[W-1];

endmodule

`default_nettype wire

>>> rtl/core/stream_min_max_mean_count.sv
// streaming set statistics: min, max, truncated fixed-point mean, threshold count
// a sample word is accepted, then runs min, max, threshold and sum steps on one adder;
//   a word with no sample or a dropped sample, if not last, is done once accepted
// a closing word then runs abs, one quotient bit per cycle through the shared adder, sign fix,
//   report load; an empty set goes from abs straight to report load
// report load waits while the report register is full, the next set starts once it is loaded
// i_rst_n is synchronous: clears the running set, the report slot, threshold back to 60
`default_nettype none

module stream_min_max_mean_count import smmmc_pkg::*; #(
    parameter int MAX_SAMPLES   = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [SAMPLE_W-1:0] i_cfg_wdata,
    smmmc_in_if.sink                 i_smp,
    smmmc_out_if.source              o_rpt
);

    // running sum holds up to 2^16 samples
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    // dividend/quotient width: |sum| shifted up by the fraction bits
    localparam int DIV_W = SUM_W + FRACTION_BITS;
    // adder width covers the dividend, the threshold compare and a sign bit
    localparam int U_W   = ((DIV_W > SAMPLE_W) ? DIV_W : SAMPLE_W) + 1;
    // width for clamping the mean
    localparam int X_W   = (U_W > MEAN_W) ? U_W : MEAN_W;
    localparam int BIT_W = $clog2(DIV_W + 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MIN  = 4'd1;
    localparam logic [3:0] ST_MAX  = 4'd2;
    localparam logic [3:0] ST_THR  = 4'd3;
    localparam logic [3:0] ST_ADD  = 4'd4;
    localparam logic [3:0] ST_ABS  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_SIGN = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_SAMPLES);

    localparam logic signed [X_W-1:0] MEAN_MAX_X = X_W'(MEAN_MAX);
    localparam logic signed [X_W-1:0] MEAN_MIN_X = X_W'(MEAN_MIN);

    logic [3:0] r_state, n_state;

    // configuration
    logic signed [SAMPLE_W-1:0]    r_thr;

    // running set
    logic signed [SUM_W-1:0]       r_sum;
    logic        [CNT_W-1:0]       r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic        [CNT_W-1:0]       r_tally;
    logic                          r_drop;

    // current word
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic                          r_last;

    // division
    logic                          r_neg;
    logic        [DIV_W-1:0]       r_quo;
    logic        [CNT_W-1:0]       r_rem;
    logic        [BIT_W-1:0]       r_bit;
    logic signed [U_W-1:0]         r_acc;

    // report slot
    logic                          r_out_valid;
    logic signed [MEAN_W-1:0]      r_mean;
    logic signed [SAMPLE_W-1:0]    r_low;
    logic signed [SAMPLE_W-1:0]    r_high;
    logic        [CNT_W-1:0]       r_pass;
    logic        [CNT_W-1:0]       r_total;
    logic                          r_ovf;

    // shared adder
    t_alu_op               alu_op;
    logic signed [U_W-1:0] alu_a;
    logic signed [U_W-1:0] alu_b;
    logic signed [U_W-1:0] alu_res;
    logic                  alu_neg;

    logic                  in_fire;
    logic                  out_fire;
    logic                  rpt_load;
    logic                  first_smp;
    logic [CNT_W:0]        div_trial;
    logic [U_W-1:0]        abs_mag;
    logic signed [X_W-1:0] acc_x;
    logic signed [MEAN_W-1:0] mean_sat;

    assign i_smp.ready = (r_state == ST_IDLE);
    assign in_fire     = i_smp.valid && i_smp.ready;
    assign out_fire    = r_out_valid && o_rpt.ready;
    // report slot is free when empty or being drained this cycle
    assign rpt_load    = (r_state == ST_OUT) && (!r_out_valid || o_rpt.ready);
    assign first_smp   = (r_cnt == '0);

    // partial remainder with the next dividend bit shifted in
    assign div_trial = {r_rem, r_quo[DIV_W-1]};

    smmmc_alu #(
        .W (U_W)
    ) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res),
        .o_neg (alu_neg)
    );

    // operand select for the shared adder, one use per state
    always_comb begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        unique case (r_state)
            ST_MIN: begin
                // smp - min < 0 means new minimum
                alu_a = U_W'(r_smp);
                alu_b = U_W'(r_min);
            end
            ST_MAX: begin
                // max - smp < 0 means new maximum
                alu_a = U_W'(r_max);
                alu_b = U_W'(r_smp);
            end
            ST_THR: begin
                // smp - thr >= 0 means passing
                alu_a = U_W'(r_smp);
                alu_b = U_W'(r_thr);
            end
            ST_ADD: begin
                alu_op = ALU_ADD;
                alu_a  = U_W'(r_sum);
                alu_b  = U_W'(r_smp);
            end
            ST_ABS: begin
                // negate the sum for its magnitude
                alu_b = U_W'(r_sum);
            end
            ST_DIV: begin
                // restoring division step, operands zero extended
                alu_a = U_W'(div_trial);
                alu_b = U_W'(r_cnt);
            end
            ST_SIGN: begin
                alu_b = U_W'(r_quo);
            end
            default: begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    assign abs_mag = r_sum[SUM_W-1] ? alu_res : U_W'(r_sum);

    // clamp the signed quotient to the report field
    assign acc_x = X_W'(r_acc);
    always_comb begin
        if (acc_x > MEAN_MAX_X) begin
            mean_sat = MEAN_MAX;
        end else if (acc_x < MEAN_MIN_X) begin
            mean_sat = MEAN_MIN;
        end else begin
            mean_sat = MEAN_W'(acc_x);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (!i_smp.no_sample && (r_cnt < CNT_CAP)) begin
                        n_state = ST_MIN;
                    end else if (i_smp.last) begin
                        n_state = ST_ABS;
                    end
                end
            end
            ST_MIN:  n_state = ST_MAX;
            ST_MAX:  n_state = ST_THR;
            ST_THR:  n_state = ST_ADD;
            ST_ADD:  n_state = r_last ? ST_ABS : ST_IDLE;
            ST_ABS:  n_state = first_smp ? ST_OUT : ST_DIV;
            ST_DIV:  n_state = (r_bit == BIT_W'(1)) ? ST_SIGN : ST_DIV;
            ST_SIGN: n_state = ST_OUT;
            ST_OUT:  n_state = rpt_load ? ST_IDLE : ST_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // running set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_cnt   <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_tally <= '0;
            r_drop  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    // sample beyond capacity is dropped and flagged
                    if (in_fire && !i_smp.no_sample && (r_cnt >= CNT_CAP)) begin
                        r_drop <= 1'b1;
                    end
                end
                ST_MIN: begin
                    if (first_smp || alu_neg) begin
                        r_min <= r_smp;
                    end
                end
                ST_MAX: begin
                    if (first_smp || alu_neg) begin
                        r_max <= r_smp;
                    end
                end
                ST_THR: begin
                    if (!alu_neg) begin
                        r_tally <= r_tally + 1'b1;
                    end
                end
                ST_ADD: begin
                    r_sum <= alu_res[SUM_W-1:0];
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_OUT: begin
                    // report taken into the slot: start a fresh set
                    if (rpt_load) begin
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_min   <= '0;
                        r_max   <= '0;
                        r_tally <= '0;
                        r_drop  <= 1'b0;
                    end
                end
                default: begin
                    r_drop <= r_drop;
                end
            endcase
        end
    end

    // word capture and division datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_smp  <= i_smp.sample[SAMPLE_BITS-1:0];
            r_last <= i_smp.last;
        end
        unique case (r_state)
            ST_ABS: begin
                r_neg <= r_sum[SUM_W-1];
                r_quo <= DIV_W'(abs_mag) << FRACTION_BITS;
                r_rem <= '0;
                r_bit <= BIT_W'(DIV_W);
                r_acc <= '0;
            end
            ST_DIV: begin
                if (!alu_neg) begin
                    r_rem <= alu_res[CNT_W-1:0];
                end else begin
                    r_rem <= div_trial[CNT_W-1:0];
                end
                r_quo <= {r_quo[DIV_W-2:0], !alu_neg};
                r_bit <= r_bit - 1'b1;
            end
            ST_SIGN: begin
                r_acc <= r_neg ? alu_res : U_W'(r_quo);
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
    end

    // report slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rpt_load) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rpt_load) begin
            r_mean  <= mean_sat;
            r_low   <= SAMPLE_W'(r_min);
            r_high  <= SAMPLE_W'(r_max);
            r_pass  <= r_tally;
            r_total <= r_cnt;
            r_ovf   <= r_drop;
        end
    end

    assign o_rpt.valid         = r_out_valid;
    assign o_rpt.mean_q8       = r_mean;
    assign o_rpt.lowest        = r_low;
    assign o_rpt.highest       = r_high;
    assign o_rpt.passing_count = r_pass;
    assign o_rpt.sample_total  = r_total;
    assign o_rpt.overflowed    = r_ovf;

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// self-checking testbench for the streaming set statistics block
module tb;
    import smmmc_pkg::*;

    // capacity of the block as built
    localparam int CAPACITY      = DEF_MAX_SAMPLES;
    localparam int FRACTION_BITS = DEF_FRACTION_BITS;

    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 600;
    localparam int WATCHDOG      = 5000;
    localparam int PHASE_WORDS   = 165;
    localparam int PHASE_COUNT   = 5;
    localparam int MAX_PRINTS    = 40;
    localparam int SPREAD_WORDS  = 10;

    localparam longint MEAN_LIMIT = MEAN_MAX;
    localparam longint MEAN_FLOOR = MEAN_MIN;

    typedef struct {
        logic signed [MEAN_W-1:0]   mean_q8;
        logic signed [SAMPLE_W-1:0] lowest;
        logic signed [SAMPLE_W-1:0] highest;
        logic        [CNT_W-1:0]    passing_count;
        logic        [CNT_W-1:0]    sample_total;
        logic                       overflowed;
    } t_stats_report;

    // running set statistics, one report expected per closing word
    class stats_scoreboard;
        t_stats_report              pending_reports[$];
        logic signed [SAMPLE_W-1:0] threshold;
        longint                     sum;
        int                         count;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        int                         tally;
        bit                         dropped;
        int                         errors;

        function new();
            threshold = THR_RESET;
            errors    = 0;
            clear_set();
        endfunction

        function void clear_set();
            sum     = 0;
            count   = 0;
            lo      = '0;
            hi      = '0;
            tally   = 0;
            dropped = 1'b0;
        endfunction

        function void set_threshold(logic signed [SAMPLE_W-1:0] value);
            threshold = value;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        // mean * 2^FRACTION_BITS, truncated toward zero, saturated
        function longint mean_fixed();
            longint unsigned mag;
            longint unsigned quo;
            if (count == 0) begin
                return 0;
            end
            mag = (sum < 0) ? -sum : sum;
            mag = mag << FRACTION_BITS;
            quo = mag / count;
            if (sum < 0) begin
                return (quo > MEAN_LIMIT + 1) ? MEAN_FLOOR : -longint'(quo);
            end
            return (quo > MEAN_LIMIT) ? MEAN_LIMIT : longint'(quo);
        endfunction

        function void note_word(logic signed [SAMPLE_W-1:0] s, logic no_sample, logic last);
            longint        mean;
            t_stats_report rpt;
            if (!no_sample) begin
                if (count >= CAPACITY) begin
                    dropped = 1'b1;
                end else begin
                    if (count == 0 || s < lo) lo = s;
                    if (count == 0 || s > hi) hi = s;
                    sum += s;
                    count++;
                    if (s >= threshold) tally++;
                end
            end
            if (last) begin
                mean              = mean_fixed();
                rpt.mean_q8       = mean[MEAN_W-1:0];
                rpt.lowest        = lo;
                rpt.highest       = hi;
                rpt.passing_count = tally[CNT_W-1:0];
                rpt.sample_total  = count[CNT_W-1:0];
                rpt.overflowed    = dropped;
                pending_reports.push_back(rpt);
                clear_set();
            end
        endfunction

        function void compare_field(string name, logic signed [63:0] exp_v,
                                    logic signed [63:0] got_v);
            if (got_v !== exp_v) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display("%0t %s expected %0d actual %0d", $time, name, exp_v, got_v);
            end
        endfunction

        function void check_report(t_stats_report got);
            t_stats_report want;
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display("%0t unexpected report expected none actual mean_q8 %0d",
                             $time, got.mean_q8);
                return;
            end
            want = pending_reports.pop_front();
            compare_field("mean_q8", want.mean_q8, got.mean_q8);
            compare_field("lowest", want.lowest, got.lowest);
            compare_field("highest", want.highest, got.highest);
            compare_field("passing_count", want.passing_count, got.passing_count);
            compare_field("sample_total", want.sample_total, got.sample_total);
            compare_field("overflowed", want.overflowed, got.overflowed);
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic        [SAMPLE_W-1:0] i_cfg_wdata;

    smmmc_in_if  smp ();
    smmmc_out_if rpt ();

    stats_scoreboard sb = new();

    // shared knobs between the stimulus and the report sink
    bit                         idle_en;
    bit                         hold_request;
    int                         hold_left;
    int                         words_sent;
    int                         quiet_cycles;
    bit                         moved;
    t_stats_report              seen;
    logic signed [SAMPLE_W-1:0] cur_threshold;

    stream_min_max_mean_count #(
        .MAX_SAMPLES(CAPACITY)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_smp      (smp),
        .o_rpt      (rpt)
    );

    // 12 unit period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // report sink: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            rpt.ready <= 1'b0;
        end else begin
            rpt.ready <= !(idle_en && $urandom_range(0, 99) < 19);
        end
    end

    // monitor: check reports before noting the word taken at the same edge,
    // and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (rpt.valid && rpt.ready) begin
                seen.mean_q8       = rpt.mean_q8;
                seen.lowest        = rpt.lowest;
                seen.highest       = rpt.highest;
                seen.passing_count = rpt.passing_count;
                seen.sample_total  = rpt.sample_total;
                seen.overflowed    = rpt.overflowed;
                sb.check_report(seen);
                moved = 1'b1;
            end
            if (smp.valid && smp.ready) begin
                sb.note_word(smp.sample, smp.no_sample, smp.last);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("stream_min_max_mean_count verification failed");
                $finish;
            end
        end
    end

    // offer one word, with random gaps before it, and wait until it is taken
    task automatic push_word(input logic signed [SAMPLE_W-1:0] s, input logic no_sample,
                             input logic last);
        @(negedge i_clk);
        while (idle_en && $urandom_range(0, 99) < 19) begin
            smp.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp.valid     <= 1'b1;
        smp.sample    <= s;
        smp.no_sample <= no_sample;
        smp.last      <= last;
        do @(posedge i_clk); while (smp.ready !== 1'b1);
        words_sent++;
    endtask

    // drop valid, wait for every report, then let the datapath go quiet
    task automatic drain_block();
        @(negedge i_clk);
        smp.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic signed [SAMPLE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        sb.set_threshold(value);
        cur_threshold = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mix of full-range values, values around the threshold, extremes and small ones
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0, 1: return $urandom;
            2, 3: return cur_threshold + int'($urandom_range(0, 8)) - 4;
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            default: return int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // one set: mostly short, sometimes longer, closed by a sample or a marker
    task automatic push_random_set();
        int len;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 7)
                                            : $urandom_range(8, 12);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 10)
                push_word($urandom, 1'b1, 1'b0);
            else
                push_word(pick_sample(), 1'b0, 1'b0);
        end
        if ($urandom_range(0, 1) == 0)
            push_word(pick_sample(), 1'b0, 1'b1);
        else
            push_word($urandom, 1'b1, 1'b1);
    endtask

    initial begin
        logic signed [SAMPLE_W-1:0] next_thr;
        int                         target;

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        smp.valid     = 1'b0;
        smp.sample    = '0;
        smp.no_sample = 1'b0;
        smp.last      = 1'b0;
        rpt.ready     = 1'b0;
        idle_en       = 1'b1;
        hold_request  = 1'b0;
        hold_left     = 0;
        words_sent    = 0;
        quiet_cycles  = 0;
        cur_threshold = THR_RESET;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, threshold at its reset value
        push_word(32'sh0, 1'b1, 1'b1);          // empty set reports zeros
        push_word(32'sh7FFF_FFFF, 1'b0, 1'b1);  // single largest sample
        push_word(32'sh8000_0000, 1'b0, 1'b1);  // single smallest sample
        // both extremes, threshold edges, a filler with all sample bits set,
        // and a sample carried on the closing word
        push_word(32'sh7FFF_FFFF, 1'b0, 1'b0);
        push_word(32'sh8000_0000, 1'b0, 1'b0);
        push_word(32'sd60, 1'b0, 1'b0);
        push_word(32'sd59, 1'b0, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        push_word(-32'sd1, 1'b0, 1'b1);
        // negative mean that truncates toward zero, closed by a bare marker
        push_word(32'sd1, 1'b0, 1'b0);
        push_word(32'sd1, 1'b0, 1'b0);
        push_word(-32'sd3, 1'b0, 1'b0);
        push_word(32'sh0, 1'b1, 1'b1);
        // a longer set spread across zero
        for (int i = 0; i < SPREAD_WORDS; i++)
            push_word(i * 1000 - 3000, 1'b0, i == SPREAD_WORDS - 1);

        // random phases, each under its own threshold
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_block();
            case (ph)
                0: next_thr = 32'sh8000_0000;
                1: next_thr = 32'sh7FFF_FFFF;
                2: next_thr = 32'sh0;
                3: next_thr = $urandom;
                default: next_thr = int'($urandom_range(0, 2000)) - 1000;
            endcase
            write_threshold(next_thr);
            // one phase runs without any gaps on either side
            idle_en = (ph != 1);
            // sink holds off while sets keep coming, so the block backs up
            if (ph == 2) hold_request = 1'b1;
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) push_random_set();
        end

        drain_block();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("stream_min_max_mean_count verification clean");
        end else begin
            $display("stream_min_max_mean_count verification failed");
        end
        $finish;
    end

endmodule
